### rtl/t3h_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and the divider lane payload type
// of the triangle stiffness core. No dependencies.
package t3h_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = 17;
	localparam int PROD_W  = 34;
	localparam int SUM_W   = 35;
	localparam int DEN_W   = 34;
	localparam int NUM_W   = 59;
	localparam int RES_W   = 32;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// Quotient bits resolved by the divider, one per stage.
	localparam int QBITS   = 32;
	// Divider depth: entry stage, one stage per quotient bit, saturation stage.
	localparam int DIV_LAT = QBITS + 2;

	localparam logic [IDX_W-1:0] REG_CONDUCTIVITY = 2'd0;
	localparam logic [IDX_W-1:0] REG_SOURCE       = 2'd1;

	localparam logic [CFG_W-1:0] CONDUCTIVITY_RESET = 16'd256;
	localparam logic [CFG_W-1:0] SOURCE_RESET       = 16'd0;

	// Load share divides by 3 * 2 * 256 (area is half of D, Q16.16 to Q16.16 via Q8.8).
	// The division is done as a shift by 9 followed by a division by three.
	localparam int LOAD_SUM_W = CFG_W + DEN_W + 1;
	localparam int LOAD_SHIFT = 9;
	localparam int LOAD_T_W   = LOAD_SUM_W - LOAD_SHIFT;
	localparam logic [LOAD_SUM_W-1:0] LOAD_HALF = 51'd768;

	// Saturation bounds on the shifted value: 3 * 2^31 and 3 * (2^31 + 1).
	localparam logic [LOAD_T_W-1:0] LOAD_POS_LIM = 42'd6442450944;
	localparam logic [LOAD_T_W-1:0] LOAD_NEG_LIM = 42'd6442450947;

	// Division by three of a value below 2^33: multiply by ceil(2^35 / 3), shift by 35.
	localparam int THIRD_LO_W  = 17;
	localparam int THIRD_HI_W  = 16;
	localparam int RECIP_W     = 34;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP_THIRD = 34'h2_AAAA_AAAB;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_in_t;

endpackage

### rtl/t3h_in_if.sv
`timescale 1ns / 1ps
// Input channel carrying the three vertex coordinates of one triangle.
// Depends on t3h_pkg.
interface t3h_in_if import t3h_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] x_first;
	logic [COORD_W-1:0] y_first;
	logic [COORD_W-1:0] x_second;
	logic [COORD_W-1:0] y_second;
	logic [COORD_W-1:0] x_third;
	logic [COORD_W-1:0] y_third;

	modport source (output valid, x_first, y_first, x_second, y_second, x_third, y_third,
		input ready);
	modport sink (input valid, x_first, y_first, x_second, y_second, x_third, y_third,
		output ready);
endinterface

### rtl/t3h_out_if.sv
`timescale 1ns / 1ps
// Output channel carrying the stiffness entries, load share and area of one triangle.
// Depends on t3h_pkg.
interface t3h_out_if import t3h_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] k_one_one;
	logic [RES_W-1:0] k_one_two;
	logic [RES_W-1:0] k_one_three;
	logic [RES_W-1:0] k_two_two;
	logic [RES_W-1:0] k_two_three;
	logic [RES_W-1:0] k_three_three;
	logic [RES_W-1:0] load_share;
	logic [DEN_W-1:0] twice_area;
	logic             degenerate;

	modport source (output valid, k_one_one, k_one_two, k_one_three, k_two_two,
		k_two_three, k_three_three, load_share, twice_area, degenerate, input ready);
	modport sink (input valid, k_one_one, k_one_two, k_one_three, k_two_two,
		k_two_three, k_three_three, load_share, twice_area, degenerate, output ready);
endinterface

### rtl/t3h_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider lane: one quotient bit per stage, rounded
// numerator supplied by the caller, signed saturation to 32 bits. Depends on t3h_pkg.
module t3h_div import t3h_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  div_in_t          din,
	output logic [RES_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [0:QBITS];
	logic [QBITS-1:0] low_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic [DEN_W-1:0] den_s [0:QBITS];
	logic             neg_s [0:QBITS];
	logic             ovf_s [0:QBITS];

	logic [DEN_W:0]   trial [0:QBITS-1];
	logic             ge    [0:QBITS-1];
	logic [DEN_W:0]   diff  [0:QBITS-1];

	always_comb begin
		for (int i = 0; i < QBITS; i++) begin
			trial[i] = {rem_s[i], low_s[i][QBITS-1]};
			ge[i]    = trial[i] >= {1'b0, den_s[i]};
			diff[i]  = trial[i] - {1'b0, den_s[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The upper numerator bits seed the remainder; if they already reach the
			// divisor the quotient needs more than 32 bits and will saturate.
			rem_s[0] <= {{(DEN_W-(NUM_W-QBITS)){1'b0}}, din.num[NUM_W-1:QBITS]};
			low_s[0] <= din.num[QBITS-1:0];
			q_s[0]   <= '0;
			den_s[0] <= din.den;
			neg_s[0] <= din.neg;
			ovf_s[0] <= {{(DEN_W-(NUM_W-QBITS)){1'b0}}, din.num[NUM_W-1:QBITS]} >= din.den;
			for (int i = 0; i < QBITS; i++) begin
				rem_s[i+1] <= ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
				low_s[i+1] <= {low_s[i][QBITS-2:0], 1'b0};
				q_s[i+1]   <= {q_s[i][QBITS-2:0], ge[i]};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
			if (neg_s[QBITS]) begin
				if (ovf_s[QBITS] || q_s[QBITS] > 32'h8000_0000)
					quo <= 32'h8000_0000;
				else
					quo <= 32'd0 - q_s[QBITS];
			end else begin
				if (ovf_s[QBITS] || q_s[QBITS] > 32'h7FFF_FFFF)
					quo <= 32'h7FFF_FFFF;
				else
					quo <= q_s[QBITS];
			end
		end
	end

endmodule

### rtl/tri3_heat_element_stiffness_core.sv
`timescale 1ns / 1ps
// Linear triangle heat-conduction stiffness and nodal load core.
// One triangle per cycle sustained while the output is not stalled.
// Depth is set by five arithmetic stages, the 34-stage divider (entry, 32 quotient bits,
// saturation) and an output stage. A stalled output holds the whole pipeline.
// arst_n clears all valid bits and loads conductivity 1.0 and source density 0.
module tri3_heat_element_stiffness_core import t3h_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	t3h_in_if.sink           tri_in,
	t3h_out_if.source        tri_out
);

	localparam int NPRE  = 5;
	localparam int NVAL  = NPRE + DIV_LAT + 1;
	localparam int NLANE = 7;
	localparam int NDIV  = 6;

	logic [CFG_W-1:0] conductivity_q;
	logic [CFG_W-1:0] source_q;

	logic            en;
	logic [NVAL-1:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conductivity_q <= CONDUCTIVITY_RESET;
			source_q       <= SOURCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONDUCTIVITY: conductivity_q <= cfg_data;
				REG_SOURCE:       source_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !tri_out.valid || tri_out.ready;
	assign tri_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[NVAL-2:0], tri_in.valid};
	end

	// Stage 1: gradient terms b and c.
	logic signed [DIFF_W-1:0] b_s1 [0:2];
	logic signed [DIFF_W-1:0] c_s1 [0:2];

	function automatic logic signed [DIFF_W-1:0] sub16(logic [COORD_W-1:0] a,
		logic [COORD_W-1:0] b);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1[0] <= sub16(tri_in.y_second, tri_in.y_third);
			b_s1[1] <= sub16(tri_in.y_third, tri_in.y_first);
			b_s1[2] <= sub16(tri_in.y_first, tri_in.y_second);
			c_s1[0] <= sub16(tri_in.x_third, tri_in.x_second);
			c_s1[1] <= sub16(tri_in.x_first, tri_in.x_third);
			c_s1[2] <= sub16(tri_in.x_second, tri_in.x_first);
		end
	end

	// Stage 2: products. The determinant reduces to c3*b2 - c2*b3 in gradient terms.
	localparam int ROW [0:5] = '{0, 0, 0, 1, 1, 2};
	localparam int COL [0:5] = '{0, 1, 2, 1, 2, 2};

	logic signed [PROD_W-1:0] bb_s2 [0:5];
	logic signed [PROD_W-1:0] cc_s2 [0:5];
	logic signed [PROD_W-1:0] da_s2;
	logic signed [PROD_W-1:0] db_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 6; e++) begin
				bb_s2[e] <= b_s1[ROW[e]] * b_s1[COL[e]];
				cc_s2[e] <= c_s1[ROW[e]] * c_s1[COL[e]];
			end
			da_s2 <= c_s1[2] * b_s1[1];
			db_s2 <= c_s1[1] * b_s1[2];
		end
	end

	// Stage 3: sums and magnitudes.
	logic signed [SUM_W-1:0] s_sum   [0:5];
	logic signed [SUM_W-1:0] det_sum;
	logic [SUM_W-1:0]        det_mag;

	logic [SUM_W-1:0] smag_s3 [0:5];
	logic [5:0]       sneg_s3;
	logic [DEN_W-1:0] d_s3;

	always_comb begin
		for (int e = 0; e < 6; e++)
			s_sum[e] = SUM_W'(bb_s2[e]) + SUM_W'(cc_s2[e]);
		det_sum = SUM_W'(da_s2) - SUM_W'(db_s2);
		det_mag = det_sum[SUM_W-1] ? SUM_W'(-det_sum) : SUM_W'(det_sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 6; e++) begin
				sneg_s3[e] <= s_sum[e][SUM_W-1];
				smag_s3[e] <= s_sum[e][SUM_W-1] ? SUM_W'(-s_sum[e]) : SUM_W'(s_sum[e]);
			end
			d_s3 <= det_mag[DEN_W-1:0];
		end
	end

	// Stage 4: scale by conductivity and by source density.
	logic [NUM_W-2:0]  kn_s4 [0:5];
	logic [5:0]        sneg_s4;
	logic [DEN_W-1:0]  d_s4;
	logic [CFG_W+DEN_W-1:0] ln_s4;
	logic              lneg_s4;
	logic [CFG_W-1:0]  src_mag;

	assign src_mag = source_q[CFG_W-1] ? CFG_W'(-source_q) : source_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 6; e++)
				kn_s4[e] <= (NUM_W-1)'(conductivity_q * smag_s3[e]) << 7;
			sneg_s4 <= sneg_s3;
			ln_s4   <= src_mag * d_s3;
			lneg_s4 <= source_q[CFG_W-1];
			d_s4    <= d_s3;
		end
	end

	// Stage 5: add half the divisor so the truncating division rounds to nearest.
	div_in_t               lane_s5 [0:NDIV-1];
	logic [DEN_W-1:0]      d_s5;
	logic [LOAD_SUM_W-1:0] lsum;
	logic [LOAD_T_W-1:0]   lt_s5;
	logic                  lneg_s5;

	assign lsum = {1'b0, ln_s4} + LOAD_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NDIV; e++) begin
				lane_s5[e].num <= {1'b0, kn_s4[e]} + NUM_W'(d_s4 >> 1);
				lane_s5[e].den <= d_s4;
				lane_s5[e].neg <= sneg_s4[e];
			end
			lt_s5   <= lsum[LOAD_SUM_W-1:LOAD_SHIFT];
			lneg_s5 <= lneg_s4;
			d_s5    <= d_s4;
		end
	end

	logic [RES_W-1:0] quo [0:NLANE-1];

	for (genvar g = 0; g < NDIV; g++) begin : g_lane
		t3h_div u_div (
			.clk (clk),
			.en  (en),
			.din (lane_s5[g]),
			.quo (quo[g])
		);
	end

	// Load share: the constant divisor is handled by a reciprocal multiply split in
	// two partial products, then delayed to line up with the divider lanes.
	logic [THIRD_LO_W+RECIP_W-1:0]  lplo_s6;
	logic [THIRD_HI_W+RECIP_W-1:0]  lphi_s6;
	logic                           lsat_s6;
	logic                           lneg_s6;
	logic [THIRD_LO_W+THIRD_HI_W+RECIP_W-1:0] lprod;
	logic [RES_W-1:0]               lq_s7;
	logic                           lsat_s7;
	logic                           lneg_s7;
	logic [RES_W-1:0]               lres_s8;
	logic [RES_W-1:0]               ld_dly_q [0:DIV_LAT-4];

	assign lprod = {lphi_s6, {THIRD_LO_W{1'b0}}} + (THIRD_LO_W+THIRD_HI_W+RECIP_W)'(lplo_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			lplo_s6 <= lt_s5[THIRD_LO_W-1:0] * RECIP_THIRD;
			lphi_s6 <= lt_s5[THIRD_LO_W+THIRD_HI_W-1:THIRD_LO_W] * RECIP_THIRD;
			lsat_s6 <= lneg_s5 ? (lt_s5 >= LOAD_NEG_LIM) : (lt_s5 >= LOAD_POS_LIM);
			lneg_s6 <= lneg_s5;
			lq_s7   <= lprod[RECIP_SHIFT+RES_W-1:RECIP_SHIFT];
			lsat_s7 <= lsat_s6;
			lneg_s7 <= lneg_s6;
			if (lsat_s7)
				lres_s8 <= lneg_s7 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else
				lres_s8 <= lneg_s7 ? 32'd0 - lq_s7 : lq_s7;
			ld_dly_q[0] <= lres_s8;
			for (int i = 1; i <= DIV_LAT-4; i++)
				ld_dly_q[i] <= ld_dly_q[i-1];
		end
	end

	assign quo[NLANE-1] = ld_dly_q[DIV_LAT-4];

	// Area travels alongside the divider lanes.
	logic [DEN_W-1:0] d_dly_q [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			d_dly_q[0] <= d_s5;
			for (int i = 1; i < DIV_LAT; i++)
				d_dly_q[i] <= d_dly_q[i-1];
		end
	end

	// Output stage: a zero determinant forces every result to zero.
	logic [RES_W-1:0] res_out_q [0:NLANE-1];
	logic [DEN_W-1:0] area_out_q;
	logic             deg_out_q;
	logic             deg_now;

	assign deg_now = d_dly_q[DIV_LAT-1] == '0;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NLANE; e++)
				res_out_q[e] <= deg_now ? '0 : quo[e];
			area_out_q <= d_dly_q[DIV_LAT-1];
			deg_out_q  <= deg_now;
		end
	end

	assign tri_out.valid         = v_q[NVAL-1];
	assign tri_out.k_one_one     = res_out_q[0];
	assign tri_out.k_one_two     = res_out_q[1];
	assign tri_out.k_one_three   = res_out_q[2];
	assign tri_out.k_two_two     = res_out_q[3];
	assign tri_out.k_two_three   = res_out_q[4];
	assign tri_out.k_three_three = res_out_q[5];
	assign tri_out.load_share    = res_out_q[6];
	assign tri_out.twice_area    = area_out_q;
	assign tri_out.degenerate    = deg_out_q;

	// The flag and the area must agree on every delivered transaction.
	a_deg_area: assert property (@(posedge clk) disable iff (!arst_n)
		tri_out.valid |-> (tri_out.degenerate == (tri_out.twice_area == '0)))
		else $error("degenerate flag disagrees with twice_area");

	// Diagonal entries come from sums of squares and can never be negative.
	a_diag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tri_out.valid |-> (!tri_out.k_one_one[RES_W-1] && !tri_out.k_two_two[RES_W-1]
			&& !tri_out.k_three_three[RES_W-1]))
		else $error("negative diagonal stiffness entry");

	// A degenerate triangle gives zero load.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tri_out.valid && tri_out.degenerate) |-> (tri_out.load_share == '0))
		else $error("load share not zeroed for degenerate triangle");

endmodule
